>>> sv/afk_pkg.sv
// shared types, constants and codes for the arm forward kinematics block
package afk_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 7;

    // field widths
    localparam int ANG_W  = 17;
    localparam int ARG_W  = 19;
    localparam int LEN_W  = 14;
    localparam int X_W    = 24;
    localparam int Y_W    = 16;
    localparam int Z_W    = 17;
    localparam int CFG_W  = 17;
    localparam int NUM_W  = 48;

    // q30 fixed point
    typedef logic [30:0]        q30_t;
    typedef logic signed [31:0] trig_t;

    localparam q30_t Q30_ONE = 31'h4000_0000;
    localparam longint DEG_TO_RAD_Q30 = 18740330;

    // sin/cos pipeline depth, from angle to registered result
    localparam int SC_LAT = 23;

    // sideways coordinate divider
    localparam int X_QBITS  = 23;
    localparam int XDIV_LAT = X_QBITS + 3;
    localparam logic signed [X_W-1:0] X_LIMIT = 24'sd8388607;

    typedef enum logic [2:0] {
        CFG_BASE_HEIGHT     = 3'd0,
        CFG_UPPER_LINK      = 3'd1,
        CFG_LOWER_LINK      = 3'd2,
        CFG_SHOULDER_OFFSET = 3'd3,
        CFG_ELBOW_OFFSET    = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

endpackage

>>> sv/arm_forward_kinematics.sv
// top level of the three-joint arm forward kinematics pipeline
// Takes one set of joint angles per beat and returns the tool position: reach y, height z and
// sideways x = y*tan(base), with x clamped to +-8388607 and flagged when clamped. The block is
// a fully pipelined datapath and accepts a new beat every clock cycle unless the output stalls;
// each beat passes through 1 input stage, sin/cos evaluation, the link products, rounding and
// the y*sin product, then a one-bit-per-stage divider for the tangent. A stalled output freezes
// the whole pipeline and nothing is lost.
// Configuration registers are meant to be written while no beat is in flight.
module arm_forward_kinematics
    import afk_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [55:0]      s_tdata,   // base_angle, shoulder_angle, elbow_angle, zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata,   // x_pos, y_pos, z_pos, zero pad
    output logic [0:0]       m_tuser,   // x_saturated
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int LAT = 1 + SC_LAT + 4 + XDIV_LAT;
    localparam int SH_OFF_I = 90 << ANGLE_FRAC_BITS;
    localparam int EL_OFF_I = -(60 << ANGLE_FRAC_BITS);
    localparam logic signed [CFG_W-1:0] SH_OFF_RST = CFG_W'(SH_OFF_I);
    localparam logic signed [CFG_W-1:0] EL_OFF_RST = CFG_W'(EL_OFF_I);

    function automatic logic signed [17:0] round_q30(input logic signed [47:0] v);
        logic [47:0] mag;
        logic [17:0] r;
        mag = v[47] ? 48'(-v) : 48'(v);
        r   = 18'((mag + 48'd536870912) >> 30);
        return v[47] ? 18'(-r) : r;
    endfunction

    logic ce;

    // configuration
    logic [LEN_W-1:0]        base_height_reg;
    logic [LEN_W-1:0]        upper_len_reg;
    logic [LEN_W-1:0]        lower_len_reg;
    logic signed [CFG_W-1:0] sh_off_reg;
    logic signed [CFG_W-1:0] el_off_reg;

    logic [LAT-1:0] vld_reg;

    // input stage
    logic signed [ANG_W-1:0] base_in, shoulder_in, elbow_in;
    logic signed [ARG_W-1:0] a1_next, a12_next;
    logic signed [ARG_W-1:0] base_reg, a1_reg, a12_reg;

    trig_t s1, c1, s12, c12, sb, cb;

    logic signed [46:0] l2c1_reg, l3c12_reg, l2s1_reg, l3s12_reg;
    trig_t              sb_p1_reg, cb_p1_reg, sb_p2_reg, cb_p2_reg, sb_p3_reg, cb_p3_reg;
    logic signed [47:0] ysum_reg, zsum_reg;
    logic signed [17:0] ry, rz;
    logic signed [Y_W-1:0] y_next, y_reg;
    logic signed [Z_W-1:0] z_next, z_reg;
    logic signed [NUM_W-1:0] num_reg;
    trig_t                   den_reg;

    logic signed [Y_W-1:0] y_d_reg [0:XDIV_LAT];
    logic signed [Z_W-1:0] z_d_reg [0:XDIV_LAT];

    logic signed [X_W-1:0] x_out;
    logic                  sat_out;

    assign ce       = m_tready || !m_tvalid;
    assign s_tready = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_height_reg <= '0;
            upper_len_reg   <= '0;
            lower_len_reg   <= '0;
            sh_off_reg      <= SH_OFF_RST;
            el_off_reg      <= EL_OFF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BASE_HEIGHT:     base_height_reg <= cfg_data[LEN_W-1:0];
                CFG_UPPER_LINK:      upper_len_reg   <= cfg_data[LEN_W-1:0];
                CFG_LOWER_LINK:      lower_len_reg   <= cfg_data[LEN_W-1:0];
                CFG_SHOULDER_OFFSET: sh_off_reg      <= cfg_data;
                CFG_ELBOW_OFFSET:    el_off_reg      <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ce)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    always_comb
    begin
        base_in     = s_tdata[16:0];
        shoulder_in = s_tdata[33:17];
        elbow_in    = s_tdata[50:34];
        a1_next     = ARG_W'(shoulder_in) + ARG_W'(sh_off_reg);
        a12_next    = a1_next + ARG_W'(elbow_in) + ARG_W'(el_off_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            base_reg <= ARG_W'(base_in);
            a1_reg   <= a1_next;
            a12_reg  <= a12_next;
        end
    end

    afk_sincos #(.FRAC(ANGLE_FRAC_BITS)) u_sc_a1
    (
        .clk(clk), .ce(ce), .angle(a1_reg), .sin_val(s1), .cos_val(c1)
    );

    afk_sincos #(.FRAC(ANGLE_FRAC_BITS)) u_sc_a12
    (
        .clk(clk), .ce(ce), .angle(a12_reg), .sin_val(s12), .cos_val(c12)
    );

    afk_sincos #(.FRAC(ANGLE_FRAC_BITS)) u_sc_base
    (
        .clk(clk), .ce(ce), .angle(base_reg), .sin_val(sb), .cos_val(cb)
    );

    always_comb
    begin
        ry     = round_q30(ysum_reg);
        rz     = round_q30(zsum_reg);
        y_next = Y_W'(ry);
        z_next = Z_W'(rz + 18'($signed({4'b0, base_height_reg})));
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            l2c1_reg  <= 47'($signed({1'b0, upper_len_reg})) * 47'(c1);
            l3c12_reg <= 47'($signed({1'b0, lower_len_reg})) * 47'(c12);
            l2s1_reg  <= 47'($signed({1'b0, upper_len_reg})) * 47'(s1);
            l3s12_reg <= 47'($signed({1'b0, lower_len_reg})) * 47'(s12);
            sb_p1_reg <= sb;
            cb_p1_reg <= cb;
            ysum_reg  <= 48'(l2c1_reg) + 48'(l3c12_reg);
            zsum_reg  <= 48'(l2s1_reg) + 48'(l3s12_reg);
            sb_p2_reg <= sb_p1_reg;
            cb_p2_reg <= cb_p1_reg;
            y_reg     <= y_next;
            z_reg     <= z_next;
            sb_p3_reg <= sb_p2_reg;
            cb_p3_reg <= cb_p2_reg;
            // tangent works from the rounded reach
            num_reg    <= NUM_W'(y_reg) * NUM_W'(sb_p3_reg);
            den_reg    <= cb_p3_reg;
            y_d_reg[0] <= y_reg;
            z_d_reg[0] <= z_reg;
            for (int i = 1; i <= XDIV_LAT; i++)
            begin
                y_d_reg[i] <= y_d_reg[i-1];
                z_d_reg[i] <= z_d_reg[i-1];
            end
        end
    end

    afk_xdiv u_xdiv
    (
        .clk(clk), .ce(ce), .num(num_reg), .den(den_reg), .x_pos(x_out), .x_sat(sat_out)
    );

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {7'd0, z_d_reg[XDIV_LAT], y_d_reg[XDIV_LAT], x_out};
    assign m_tuser  = sat_out;

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && sat_out |-> (x_out == X_LIMIT || x_out == -X_LIMIT))
        else $error("saturated beat without x at the limit");

    a_zero_reach: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && y_d_reg[XDIV_LAT] == '0 |-> x_out == '0 && !sat_out)
        else $error("zero reach gave nonzero sideways position");

    a_sat_needs_reach: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && sat_out |-> y_d_reg[XDIV_LAT] != '0)
        else $error("clamp flagged on a beat with zero reach");

endmodule

>>> sv/afk_rdiv.sv
// two-stage q30 step: one minus the input divided by a constant, truncated
module afk_rdiv
    import afk_pkg::*;
#(
    parameter int DIVISOR = 2
)
(
    input  logic clk,
    input  logic ce,
    input  q30_t v,
    output q30_t p
);

    localparam int SH = 31;
    localparam longint RECIP_L = (longint'(1) << SH) / DIVISOR;
    localparam logic [30:0] RECIP = 31'(RECIP_L);

    logic [61:0] prod;
    q30_t        qe_next;
    q30_t        qe_reg;
    q30_t        v_reg;
    logic [31:0] rem;
    logic        bump;
    q30_t        p_next;
    q30_t        p_reg;

    // estimate is low by at most one
    always_comb
    begin
        prod    = 62'(v) * 62'(RECIP);
        qe_next = prod[61:31];
    end

    always_comb
    begin
        rem    = 32'(v_reg) - 32'(qe_reg * DIVISOR);
        bump   = rem >= 32'(DIVISOR);
        p_next = Q30_ONE - qe_reg - 31'(bump);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            qe_reg <= qe_next;
            v_reg  <= v;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

>>> sv/afk_sincos.sv
// pipelined fixed-point sine and cosine of an angle in fractional degrees
module afk_sincos
    import afk_pkg::*;
#(
    parameter int FRAC = ANGLE_FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    ce,
    input  logic signed [ARG_W-1:0] angle,
    output trig_t                   sin_val,
    output trig_t                   cos_val
);

    localparam int FULL    = 360 << FRAC;
    localparam int QUARTER = 90 << FRAC;
    localparam int OCTANT  = 45 << FRAC;
    localparam int SPAN    = 1 << (ARG_W - 1);
    localparam int OFF     = ((SPAN + FULL - 1) / FULL) * FULL;
    localparam int UW      = $clog2(OFF + SPAN);
    localparam int RECIP   = (1 << UW) / FULL;
    localparam int RCW     = $clog2(RECIP + 1);
    localparam int QW      = $clog2((OFF + SPAN) / FULL + 1);
    localparam int FW      = $clog2(FULL);
    localparam int MW      = $clog2(QUARTER);
    localparam int TW      = $clog2(OCTANT + 1);

    function automatic q30_t mulq(input q30_t a, input q30_t b);
        logic [61:0] pr;
        pr = 62'(a) * 62'(b);
        return pr[60:30];
    endfunction

    // angle reduction
    logic [UW:0]       a_ext;
    logic [UW-1:0]     u_next;
    logic [UW-1:0]     u_reg;
    logic [UW+RCW-1:0] qprod;
    logic [QW-1:0]     qe_next;
    logic [QW-1:0]     qe_reg;
    logic [UW-1:0]     u2_reg;
    logic [UW-1:0]     r0_next;
    logic [UW-1:0]     r0_reg;
    logic [FW-1:0]     r_next;
    logic [FW-1:0]     r_reg;
    quad_t             quad_next;
    logic [MW-1:0]     rem_next;
    logic [MW-1:0]     rem_reg;
    logic              swap_next;
    logic [TW-1:0]     t_next;
    logic [TW-1:0]     t_reg;
    logic [TW+24:0]    xprod;
    q30_t              x_next;
    q30_t              x_reg;

    // carried along the polynomial stages
    quad_t quad_d_reg [0:17];
    logic  swap_d_reg [0:16];
    q30_t  x2_d_reg   [0:11];
    q30_t  x_d_reg    [0:11];

    // horner chains
    q30_t sin_p1, sin_p2, sin_p3, sin_p4;
    q30_t cos_p1, cos_p2, cos_p3, cos_p4, cos_pc;
    q30_t sm1_reg, sm2_reg, sm3_reg, ps_reg, ps_d1_reg, ps_d2_reg;
    q30_t cm1_reg, cm2_reg, cm3_reg, cm4_reg;

    trig_t sr, cr, s_next, c_next, sin_reg, cos_reg;

    always_comb
    begin
        a_ext   = {{(UW + 1 - ARG_W){angle[ARG_W-1]}}, angle};
        u_next  = UW'(a_ext + (UW + 1)'(OFF));
        qprod   = (UW + RCW)'(u_reg) * (UW + RCW)'(RECIP);
        qe_next = QW'(qprod >> UW);
        r0_next = u2_reg - UW'(qe_reg * FULL);
        r_next  = (r0_reg >= UW'(FULL)) ? FW'(r0_reg - UW'(FULL)) : FW'(r0_reg);
    end

    always_comb
    begin
        if (r_reg >= FW'(3 * QUARTER))
        begin
            quad_next = QUAD_IV;
            rem_next  = MW'(r_reg - FW'(3 * QUARTER));
        end
        else if (r_reg >= FW'(2 * QUARTER))
        begin
            quad_next = QUAD_III;
            rem_next  = MW'(r_reg - FW'(2 * QUARTER));
        end
        else if (r_reg >= FW'(QUARTER))
        begin
            quad_next = QUAD_II;
            rem_next  = MW'(r_reg - FW'(QUARTER));
        end
        else
        begin
            quad_next = QUAD_I;
            rem_next  = MW'(r_reg);
        end
    end

    // fold into the first octant
    always_comb
    begin
        swap_next = rem_reg > MW'(OCTANT);
        t_next    = swap_next ? TW'(QUARTER - rem_reg) : TW'(rem_reg);
        xprod     = (TW + 25)'(t_reg) * (TW + 25)'(DEG_TO_RAD_Q30);
        x_next    = q30_t'(xprod >> FRAC);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            u_reg         <= u_next;
            qe_reg        <= qe_next;
            u2_reg        <= u_reg;
            r0_reg        <= r0_next;
            r_reg         <= r_next;
            rem_reg       <= rem_next;
            quad_d_reg[0] <= quad_next;
            t_reg         <= t_next;
            swap_d_reg[0] <= swap_next;
            x_reg         <= x_next;
            x2_d_reg[0]   <= mulq(x_reg, x_reg);
            x_d_reg[0]    <= x_reg;
            for (int i = 1; i < 18; i++)
                quad_d_reg[i] <= quad_d_reg[i-1];
            for (int i = 1; i < 17; i++)
                swap_d_reg[i] <= swap_d_reg[i-1];
            for (int i = 1; i < 12; i++)
            begin
                x2_d_reg[i] <= x2_d_reg[i-1];
                x_d_reg[i]  <= x_d_reg[i-1];
            end
            sm1_reg   <= mulq(x2_d_reg[2], sin_p1);
            sm2_reg   <= mulq(x2_d_reg[5], sin_p2);
            sm3_reg   <= mulq(x2_d_reg[8], sin_p3);
            ps_reg    <= mulq(x_d_reg[11], sin_p4);
            ps_d1_reg <= ps_reg;
            ps_d2_reg <= ps_d1_reg;
            cm1_reg   <= mulq(x2_d_reg[2], cos_p1);
            cm2_reg   <= mulq(x2_d_reg[5], cos_p2);
            cm3_reg   <= mulq(x2_d_reg[8], cos_p3);
            cm4_reg   <= mulq(x2_d_reg[11], cos_p4);
            sin_reg   <= s_next;
            cos_reg   <= c_next;
        end
    end

    afk_rdiv #(.DIVISOR(72)) u_sin72 (.clk(clk), .ce(ce), .v(x2_d_reg[0]), .p(sin_p1));
    afk_rdiv #(.DIVISOR(42)) u_sin42 (.clk(clk), .ce(ce), .v(sm1_reg), .p(sin_p2));
    afk_rdiv #(.DIVISOR(20)) u_sin20 (.clk(clk), .ce(ce), .v(sm2_reg), .p(sin_p3));
    afk_rdiv #(.DIVISOR(6))  u_sin6  (.clk(clk), .ce(ce), .v(sm3_reg), .p(sin_p4));

    afk_rdiv #(.DIVISOR(90)) u_cos90 (.clk(clk), .ce(ce), .v(x2_d_reg[0]), .p(cos_p1));
    afk_rdiv #(.DIVISOR(56)) u_cos56 (.clk(clk), .ce(ce), .v(cm1_reg), .p(cos_p2));
    afk_rdiv #(.DIVISOR(30)) u_cos30 (.clk(clk), .ce(ce), .v(cm2_reg), .p(cos_p3));
    afk_rdiv #(.DIVISOR(12)) u_cos12 (.clk(clk), .ce(ce), .v(cm3_reg), .p(cos_p4));
    afk_rdiv #(.DIVISOR(2))  u_cos2  (.clk(clk), .ce(ce), .v(cm4_reg), .p(cos_pc));

    // unfold octant and quadrant
    always_comb
    begin
        sr = swap_d_reg[16] ? trig_t'({1'b0, cos_pc}) : trig_t'({1'b0, ps_d2_reg});
        cr = swap_d_reg[16] ? trig_t'({1'b0, ps_d2_reg}) : trig_t'({1'b0, cos_pc});
        case (quad_d_reg[17])
            QUAD_I:
            begin
                s_next = sr;
                c_next = cr;
            end
            QUAD_II:
            begin
                s_next = cr;
                c_next = -sr;
            end
            QUAD_III:
            begin
                s_next = -sr;
                c_next = -cr;
            end
            QUAD_IV:
            begin
                s_next = -cr;
                c_next = sr;
            end
            default:
            begin
                s_next = sr;
                c_next = cr;
            end
        endcase
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

>>> sv/afk_xdiv.sv
// pipelined signed divide with clamp for the sideways coordinate
module afk_xdiv
    import afk_pkg::*;
(
    input  logic                    clk,
    input  logic                    ce,
    input  logic signed [NUM_W-1:0] num,
    input  trig_t                   den,
    output logic signed [X_W-1:0]   x_pos,
    output logic                    x_sat
);

    localparam int QB = X_QBITS;
    localparam int DW = 32 + QB;

    logic [NUM_W-1:0] absn_reg;
    logic [31:0]      absd_a_reg;
    logic             neg_a_reg;
    logic             nz_a_reg;

    logic [DW-1:0] rem_reg  [0:QB];
    logic [QB-1:0] quo_reg  [0:QB];
    logic [31:0]   absd_reg [0:QB];
    logic          neg_reg  [0:QB];
    logic          nz_reg   [0:QB];
    logic          sat_reg  [0:QB];

    logic signed [X_W-1:0] x_next;
    logic signed [X_W-1:0] x_reg;
    logic                  sat_out_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            absn_reg   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            absd_a_reg <= den[31] ? 32'(-den) : 32'(den);
            neg_a_reg  <= num[NUM_W-1] ^ den[31];
            nz_a_reg   <= num != '0;
            // quotient would not fit, or divisor is zero with a nonzero numerator
            sat_reg[0]  <= nz_a_reg && (DW'(absn_reg) >= (DW'(absd_a_reg) << QB));
            rem_reg[0]  <= DW'(absn_reg);
            quo_reg[0]  <= '0;
            absd_reg[0] <= absd_a_reg;
            neg_reg[0]  <= neg_a_reg;
            nz_reg[0]   <= nz_a_reg;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [DW-1:0] trial;
        logic          take;

        always_comb
        begin
            trial = DW'(absd_reg[k]) << (QB - 1 - k);
            take  = rem_reg[k] >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[k+1]  <= take ? (rem_reg[k] - trial) : rem_reg[k];
                quo_reg[k+1]  <= {quo_reg[k][QB-2:0], take};
                absd_reg[k+1] <= absd_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                nz_reg[k+1]   <= nz_reg[k];
                sat_reg[k+1]  <= sat_reg[k];
            end
        end
    end

    always_comb
    begin
        if (sat_reg[QB])
            x_next = neg_reg[QB] ? -X_LIMIT : X_LIMIT;
        else if (!nz_reg[QB])
            x_next = '0;
        else if (neg_reg[QB])
            x_next = -$signed({1'b0, quo_reg[QB]});
        else
            x_next = $signed({1'b0, quo_reg[QB]});
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg       <= x_next;
            sat_out_reg <= sat_reg[QB];
        end
    end

    assign x_pos = x_reg;
    assign x_sat = sat_out_reg;

endmodule
